### sv/pdtg_pkg.sv
// ----------------------------------------------------------------------------
// pdtg_pkg
// Types and fixed constants shared by the 1 PPS disciplined tick generator.
// ----------------------------------------------------------------------------
package pdtg_pkg;

    // Width of the interval index inside one 1/64 s period.
    localparam int unsigned IDX_W = 5;

    // Largest phase difference, in timer ticks, that one phasing step corrects.
    localparam logic [15:0] PHASE_CAP = 16'd12000;

    // Rate step magnitude above which the stability tracking restarts.
    localparam logic signed [31:0] RATE_LIMIT = 32'sd500000;

    // Capture values below this count follow a timer overflow in the same event.
    localparam logic [15:0] HALF_RANGE = 16'd32768;

    // Stability count at which a ready bit is raised.
    localparam logic [1:0] STABLE_DONE = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] CFG_NOMINAL  = 8'd0;
    localparam logic [7:0] CFG_EXPECTED = 8'd1;
    localparam logic [7:0] CFG_LOW      = 8'd2;
    localparam logic [7:0] CFG_HIGH     = 8'd3;

    // Configuration reset values.
    localparam logic [15:0] NOMINAL_RST  = 16'd50000;
    localparam logic [31:0] EXPECTED_RST = 32'd64000000;
    localparam logic [31:0] LOW_RST      = 32'd57600000;
    localparam logic [31:0] HIGH_RST     = 32'd70400000;

    // Which timer flags one event carries.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_COMPARE = 2'd1,
        EV_CAPTURE = 2'd2,
        EV_BOTH    = 2'd3
    } t_event;

    // One classified event as it travels from the front end to the back end.
    typedef struct packed {
        t_event      ev;
        logic [15:0] cap_value;
        logic [31:0] cap_time;
        logic        load;
        logic [63:0] new_time;
    } t_item;

    // Schedule state that the phasing and advance steps work on.
    typedef struct packed {
        logic [15:0]     cmp;
        logic [15:0]     prev_cmp;
        logic [IDX_W-1:0] idx;
        logic [31:0]     rate_acc;
        logic [31:0]     phase_acc;
        logic [31:0]     phase_step;
        logic [63:0]     time_count;
        logic [15:0]     early_fix;
        logic [15:0]     late_fix;
        logic            load_pending;
        logic [63:0]     load_value;
        logic            tick;
        logic            jam;
    } t_sched;

endpackage

### sv/pdtg_front.sv
// ----------------------------------------------------------------------------
// pdtg_front
// Accepts timer events, extends the capture count to 32 bits and classifies
// the event for the back end.
// ----------------------------------------------------------------------------
module pdtg_front
    import pdtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_overflow_event,
    input  logic        i_capture_event,
    input  logic        i_compare_event,
    input  logic [15:0] i_capture_value,
    input  logic        i_load_time,
    input  logic [63:0] i_new_time,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [15:0] r_timer_high;
    logic [15:0] n_timer_high;
    logic [31:0] cap_ext;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        cap_ext = {r_timer_high, i_capture_value};
        if (i_overflow_event && (i_capture_value < HALF_RANGE)) begin
            cap_ext = cap_ext + 32'h0001_0000;
        end
        n_timer_high = r_timer_high + 16'(i_overflow_event);
    end

    always_comb begin
        o_item.ev        = t_event'({i_capture_event, i_compare_event});
        o_item.cap_value = i_capture_value;
        o_item.cap_time  = cap_ext;
        o_item.load      = i_load_time;
        o_item.new_time  = i_new_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_high <= '0;
        end else if (o_push) begin
            r_timer_high <= n_timer_high;
        end
    end

endmodule

### sv/pdtg_queue.sv
// ----------------------------------------------------------------------------
// pdtg_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pdtg_queue
    import pdtg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### sv/pdtg_back.sv
// ----------------------------------------------------------------------------
// pdtg_back
// Carries out one event a cycle unless the output waits: phasing or jamming,
// schedule advance, the per-second rate measurement, and the result register.
// ----------------------------------------------------------------------------
module pdtg_back
    import pdtg_pkg::*;
#(
    parameter int unsigned INTERVALS     = 20,
    parameter int unsigned FRACTION_BITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_pop,
    input  t_item       i_item,
    input  logic [15:0] i_nominal,
    input  logic [31:0] i_expected,
    input  logic [31:0] i_low_limit,
    input  logic [31:0] i_high_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_compare_value,
    output logic        o_sync_tick,
    output logic [63:0] o_time_now,
    output logic [31:0] o_capture_time,
    output logic [1:0]  o_ready_flags,
    output logic [15:0] o_rate_errors,
    output logic        o_resynced
);

    // Exact division by INTERVALS for any 32-bit value: multiply by the
    // rounded-up reciprocal and shift.
    localparam int unsigned     DIV_SHIFT = 37;
    localparam logic [37:0]     DIV_RECIP =
        38'(((64'd1 << DIV_SHIFT) + 64'(INTERVALS) - 64'd1) / 64'(INTERVALS));
    localparam int unsigned     RATE_SHIFT = FRACTION_BITS - 6;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(INTERVALS - 1);
    localparam logic [IDX_W-1:0] END_IDX   = IDX_W'(INTERVALS);

    function automatic logic [31:0] div_intervals(input logic [31:0] x);
        logic [69:0] prod;
        prod = 70'(x) * 70'(DIV_RECIP);
        return 32'(prod >> DIV_SHIFT);
    endfunction

    function automatic logic [31:0] whole_part(input logic [31:0] s);
        logic signed [31:0] w;
        w = $signed(s) >>> FRACTION_BITS;
        if (s[31] && (|s[FRACTION_BITS-1:0])) begin
            w = w + 32'sd1;
        end
        return w;
    endfunction

    function automatic t_sched advance(input t_sched st, input logic [15:0] nom,
                                       input logic [31:0] rstep);
        t_sched      o;
        logic [31:0] rs;
        logic [31:0] ps;
        logic [31:0] wr;
        logic [31:0] wp;
        o = st;
        o.idx = st.idx + IDX_W'(1);
        if (o.idx >= END_IDX) begin
            o.tick       = 1'b1;
            o.time_count = st.time_count + 64'd1;
            if (st.load_pending) begin
                o.time_count   = st.load_value;
                o.load_pending = 1'b0;
            end
            o.idx = '0;
        end
        rs          = st.rate_acc + rstep;
        wr          = whole_part(rs);
        o.rate_acc  = rs - (wr << FRACTION_BITS);
        ps          = st.phase_acc + st.phase_step;
        wp          = whole_part(ps);
        o.phase_acc = ps - (wp << FRACTION_BITS);
        o.prev_cmp  = st.cmp;
        o.cmp       = st.cmp + nom + wr[15:0] + wp[15:0];
        return o;
    endfunction

    function automatic t_sched phase(input t_sched st, input logic [15:0] cv,
                                     input logic [15:0] nom);
        t_sched      o;
        logic [15:0] d;
        logic [31:0] q;
        o = st;
        d = '0;
        q = '0;
        if (st.idx == '0) begin
            d = cv - st.prev_cmp;
            if (d > PHASE_CAP) begin
                d = PHASE_CAP;
            end
            q            = div_intervals(32'(d) << RATE_SHIFT);
            o.phase_step = q;
            if (st.time_count[5:0] != 6'h00) begin
                o.time_count[5:0] = 6'h00;
                o.early_fix       = st.early_fix + 16'd1;
            end
        end else if (st.idx == LAST_IDX) begin
            d = st.cmp - cv;
            if (d > PHASE_CAP) begin
                d = PHASE_CAP;
            end
            q            = div_intervals(32'(d) << RATE_SHIFT);
            o.phase_step = -q;
            if (st.time_count[5:0] != 6'h3f) begin
                o.time_count[5:0] = 6'h3f;
                o.late_fix        = st.late_fix + 16'd1;
            end
        end else begin
            o.cmp        = cv + nom;
            o.idx        = '0;
            o.phase_step = '0;
            o.jam        = 1'b1;
        end
        return o;
    endfunction

    t_sched      r_st;
    logic [31:0] r_rate_step;
    logic [31:0] r_prev_cap;
    logic [31:0] r_latest_cap;
    logic [15:0] r_early_seen;
    logic [15:0] r_late_seen;
    logic [1:0]  r_early_stable;
    logic [1:0]  r_late_stable;
    logic [1:0]  r_ready;
    logic [15:0] r_rate_err;

    t_sched      s0;
    t_sched      s1;
    t_sched      s2;
    logic        is_cap;
    logic        is_cmp;
    logic        phase_first;
    logic [31:0] n_rate_step;
    logic [31:0] n_latest_cap;
    logic [15:0] n_early_seen;
    logic [15:0] n_late_seen;
    logic [1:0]  n_early_stable;
    logic [1:0]  n_late_stable;
    logic [1:0]  n_ready;
    logic [15:0] n_rate_err;
    logic [31:0] ticks;
    logic signed [31:0] dev;
    logic signed [63:0] prod_wide;
    logic signed [31:0] prod_sat;
    logic [31:0] mag;
    logic [31:0] quo;

    assign o_pop  = i_q_valid && (!o_out_valid || i_out_ready);
    assign is_cap = (i_item.ev == EV_CAPTURE) || (i_item.ev == EV_BOTH);
    assign is_cmp = (i_item.ev == EV_COMPARE) || (i_item.ev == EV_BOTH);

    // Schedule part: phasing and advance in the order the event calls for.
    always_comb begin
        s0     = r_st;
        s0.tick = 1'b0;
        s0.jam  = 1'b0;
        if (i_item.load) begin
            s0.load_pending = 1'b1;
            s0.load_value   = i_item.new_time;
        end
        phase_first = is_cap && (!is_cmp || (i_item.cap_value - r_st.cmp) > 16'd32767);
        if (phase_first) begin
            s1 = phase(s0, i_item.cap_value, i_nominal);
            s2 = is_cmp ? advance(s1, i_nominal, r_rate_step) : s1;
        end else begin
            s1 = is_cmp ? advance(s0, i_nominal, r_rate_step) : s0;
            s2 = is_cap ? phase(s1, i_item.cap_value, i_nominal) : s1;
        end
    end

    // Per-second measurement on a capture.
    always_comb begin
        n_rate_step    = r_rate_step;
        n_latest_cap   = r_latest_cap;
        n_early_seen   = r_early_seen;
        n_late_seen    = r_late_seen;
        n_early_stable = r_early_stable;
        n_late_stable  = r_late_stable;
        n_ready        = r_ready;
        n_rate_err     = r_rate_err;
        ticks          = i_item.cap_time - r_prev_cap;
        dev            = $signed(ticks - i_expected);
        prod_wide      = 64'(dev) <<< RATE_SHIFT;
        if (prod_wide > 64'sd2147483647) begin
            prod_sat = 32'sh7fff_ffff;
        end else if (prod_wide < -64'sd2147483648) begin
            prod_sat = 32'sh8000_0000;
        end else begin
            prod_sat = 32'(prod_wide);
        end
        mag = prod_sat[31] ? -prod_sat : prod_sat;
        quo = div_intervals(mag);
        if (is_cap) begin
            n_latest_cap = i_item.cap_time;
            if ((ticks > i_low_limit) && (ticks < i_high_limit)) begin
                n_rate_step = prod_sat[31] ? -quo : quo;
            end else if (r_rate_err != 16'hffff) begin
                n_rate_err = r_rate_err + 16'd1;
            end
            if (s2.early_fix != r_early_seen) begin
                n_early_seen   = s2.early_fix;
                n_early_stable = '0;
                n_ready[0]     = 1'b0;
            end else if (r_early_stable >= STABLE_DONE) begin
                n_ready[0] = 1'b1;
            end else begin
                n_early_stable = r_early_stable + 2'd1;
            end
            if (s2.late_fix != r_late_seen) begin
                n_late_seen   = s2.late_fix;
                n_late_stable = '0;
                n_ready[1]    = 1'b0;
            end else if (r_late_stable >= STABLE_DONE) begin
                n_ready[1] = 1'b1;
            end else begin
                n_late_stable = r_late_stable + 2'd1;
            end
            if (($signed(n_rate_step) > RATE_LIMIT) || ($signed(n_rate_step) < -RATE_LIMIT)) begin
                n_early_stable = '0;
                n_late_stable  = '0;
                n_ready        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st           <= '0;
            r_rate_step    <= '0;
            r_prev_cap     <= '0;
            r_latest_cap   <= '0;
            r_early_seen   <= '0;
            r_late_seen    <= '0;
            r_early_stable <= '0;
            r_late_stable  <= '0;
            r_ready        <= '0;
            r_rate_err     <= '0;
            o_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_st           <= s2;
                r_rate_step    <= n_rate_step;
                r_prev_cap     <= is_cap ? i_item.cap_time : r_prev_cap;
                r_latest_cap   <= n_latest_cap;
                r_early_seen   <= n_early_seen;
                r_late_seen    <= n_late_seen;
                r_early_stable <= n_early_stable;
                r_late_stable  <= n_late_stable;
                r_ready        <= n_ready;
                r_rate_err     <= n_rate_err;
                o_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_compare_value <= s2.cmp;
            o_sync_tick     <= s2.tick;
            o_time_now      <= s2.time_count;
            o_capture_time  <= n_latest_cap;
            o_ready_flags   <= n_ready;
            o_rate_errors   <= n_rate_err;
            o_resynced      <= s2.jam;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.idx < END_IDX) else $error("interval index out of range");

    a_jam_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && s2.jam) |-> is_cap) else $error("jam without capture");

    a_tick_needs_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && s2.tick) |-> is_cmp) else $error("tick without compare");

    a_err_count_moves_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rate_err == $past(r_rate_err)) || (r_rate_err == $past(r_rate_err) + 16'd1)
        || (r_rate_err == 16'd0)) else $error("rate error count jumped");

endmodule

### sv/pps_disciplined_tick_generator.sv
// ----------------------------------------------------------------------------
// pps_disciplined_tick_generator
// GPS 1 PPS disciplined timebase driven by events of a 16-bit timer.
// ----------------------------------------------------------------------------
// Each input beat is one timer event (overflow, 1 PPS capture, compare) and
// yields exactly one output beat with the next compare time, the 1/64 s sync
// tick, the 64-bit time count, the extended capture time, the ready bits,
// the rate error count and the jam flag. The block takes one beat every clock
// cycle while the two-entry event queue is not full. An accepted beat is
// written into that queue; at its head, the back end's combinational step
// (phasing, schedule advance, rate measurement with a reciprocal multiply for
// the division by INTERVALS) computes its result into the output register,
// and that step sets the clock rate. The queue lets new beats enter while a
// finished result waits in the output register to be taken.
// Configuration writes are taken in any cycle and must only be issued while
// no event is in flight.
module pps_disciplined_tick_generator
    import pdtg_pkg::*;
#(
    parameter int unsigned INTERVALS     = 20,
    parameter int unsigned FRACTION_BITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Event channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_overflow_event,
    input  logic        i_capture_event,
    input  logic        i_compare_event,
    input  logic [15:0] i_capture_value,
    input  logic        i_load_time,
    input  logic [63:0] i_new_time,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_compare_value,
    output logic        o_sync_tick,
    output logic [63:0] o_time_now,
    output logic [31:0] o_capture_time,
    output logic [1:0]  o_ready_flags,
    output logic [15:0] o_rate_errors,
    output logic        o_resynced
);

    // Configuration registers. Writes to unknown indexes are dropped.
    logic [15:0] r_nominal;
    logic [31:0] r_expected;
    logic [31:0] r_low;
    logic [31:0] r_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal  <= NOMINAL_RST;
            r_expected <= EXPECTED_RST;
            r_low      <= LOW_RST;
            r_high     <= HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NOMINAL:  r_nominal  <= i_cfg_data[15:0];
                CFG_EXPECTED: r_expected <= i_cfg_data;
                CFG_LOW:      r_low      <= i_cfg_data;
                CFG_HIGH:     r_high     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end extends captures to 32 bits and classifies events; the
    // queue lets it keep accepting while the back end waits on the output.
    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_item item_in;
    t_item item_out;

    pdtg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_overflow_event (i_overflow_event),
        .i_capture_event  (i_capture_event),
        .i_compare_event  (i_compare_event),
        .i_capture_value  (i_capture_value),
        .i_load_time      (i_load_time),
        .i_new_time       (i_new_time),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (item_in)
    );

    pdtg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (item_out)
    );

    // The back end holds the schedule, the accumulators and the result
    // register.
    pdtg_back #(
        .INTERVALS     (INTERVALS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_pop           (pop),
        .i_item          (item_out),
        .i_nominal       (r_nominal),
        .i_expected      (r_expected),
        .i_low_limit     (r_low),
        .i_high_limit    (r_high),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_compare_value (o_compare_value),
        .o_sync_tick     (o_sync_tick),
        .o_time_now      (o_time_now),
        .o_capture_time  (o_capture_time),
        .o_ready_flags   (o_ready_flags),
        .o_rate_errors   (o_rate_errors),
        .o_resynced      (o_resynced)
    );

endmodule

### sim/tb_pps_disciplined_tick_generator.sv
// ----------------------------------------------------------------------------
// tb_pps_disciplined_tick_generator
// Self-checking bench for the 1 PPS disciplined tick generator.
// ----------------------------------------------------------------------------
// A queue of timer events is filled by the stimulus process and fed to the
// block by a clocked driver with random idle bursts. A clocked monitor takes
// each result beat, with random stall bursts and one long hold-off, and
// compares it with the output of a behavioral timebase model that is updated
// as each event beat is accepted.
// ----------------------------------------------------------------------------
module tb_pps_disciplined_tick_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import pdtg_pkg::*;

    localparam int unsigned NINT    = 20;
    localparam int unsigned FRAC    = 18;
    localparam int          WDOG_MAX = 5000;

    // One timer event as offered on the event channel.
    typedef struct packed {
        logic        ovf;
        logic        cap;
        logic        cmp;
        logic [15:0] cval;
        logic        load;
        logic [63:0] ntime;
    } ev_t;

    // One expected result beat.
    typedef struct packed {
        logic [15:0] compare_value;
        logic        sync_tick;
        logic [63:0] time_now;
        logic [31:0] capture_time;
        logic [1:0]  ready_flags;
        logic [15:0] rate_errors;
        logic        resynced;
    } tb_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_overflow_event;
    logic        i_capture_event;
    logic        i_compare_event;
    logic [15:0] i_capture_value;
    logic        i_load_time;
    logic [63:0] i_new_time;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_compare_value;
    logic        o_sync_tick;
    logic [63:0] o_time_now;
    logic [31:0] o_capture_time;
    logic [1:0]  o_ready_flags;
    logic [15:0] o_rate_errors;
    logic        o_resynced;

    pps_disciplined_tick_generator dut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Pending events, expected results and control between the processes.
    ev_t     event_q[$];
    tb_res_t timebase_q[$];
    int      errors;
    int      idle_cycles;
    bit      quiet_mode;    // Last part of the run: no idle or stall bursts.
    bit      hold_request;  // Ask the receiver for one long hold-off.
    bit      hold_done;

    // Model configuration.
    logic [15:0] m_nominal;
    logic [31:0] m_expected, m_low, m_high;

    // Model state.
    logic [15:0] m_timer_high, m_cmp, m_prev_cmp;
    logic [31:0] m_latest, m_prev_cap;
    logic [4:0]  m_idx;
    logic signed [31:0] m_rate_step, m_phase_step, m_rate_acc, m_phase_acc;
    logic [63:0] m_time;
    logic [15:0] m_early_fix, m_late_fix, m_early_seen, m_late_seen;
    logic [1:0]  m_early_st, m_late_st, m_ready;
    logic [15:0] m_rate_err;
    logic        m_load_pend;
    logic [63:0] m_load_val;
    logic        m_jam, m_tick;

    // Adds a step to an accumulator and strips the truncated whole part.
    function automatic longint take_whole(ref logic signed [31:0] acc,
                                          input logic signed [31:0] step);
        logic signed [31:0] s;
        longint w;
        s = acc + step;
        w = longint'(s) / (longint'(1) << FRAC);
        acc = 32'(longint'(s) - w * (longint'(1) << FRAC));
        return w;
    endfunction

    task automatic timebase_advance();
        longint w1, w2;
        m_idx = m_idx + 5'd1;
        if (m_idx >= NINT) begin
            m_tick = 1'b1;
            m_time = m_time + 64'd1;
            if (m_load_pend) begin
                m_time = m_load_val;
                m_load_pend = 1'b0;
            end
            m_idx = '0;
        end
        w1 = take_whole(m_rate_acc, m_rate_step);
        w2 = take_whole(m_phase_acc, m_phase_step);
        m_prev_cmp = m_cmp;
        m_cmp = 16'(longint'(m_cmp) + longint'(m_nominal) + w1 + w2);
    endtask

    task automatic timebase_phase(input logic [15:0] cv);
        logic [15:0] d;
        if (m_idx == 0) begin
            d = cv - m_prev_cmp;
            if (d > PHASE_CAP) d = PHASE_CAP;
            m_phase_step = 32'((longint'(d) << (FRAC - 6)) / NINT);
            if (m_time[5:0] != 6'd0) begin
                m_time[5:0] = 6'd0;
                m_early_fix = m_early_fix + 16'd1;
            end
        end else if (m_idx == NINT - 1) begin
            d = m_cmp - cv;
            if (d > PHASE_CAP) d = PHASE_CAP;
            m_phase_step = 32'(-((longint'(d) << (FRAC - 6)) / NINT));
            if (m_time[5:0] != 6'h3f) begin
                m_time[5:0] = 6'h3f;
                m_late_fix = m_late_fix + 16'd1;
            end
        end else begin
            // Capture outside the phase window: jam the schedule.
            m_cmp = cv + m_nominal;
            m_idx = '0;
            m_phase_step = '0;
            m_jam = 1'b1;
        end
    endtask

    task automatic timebase_measure();
        logic [31:0] ticks;
        logic [31:0] dev;
        longint p;
        ticks = m_latest - m_prev_cap;
        m_prev_cap = m_latest;
        if (ticks > m_low && ticks < m_high) begin
            dev = ticks - m_expected;
            p = longint'($signed(dev)) * (longint'(1) << (FRAC - 6));
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            // Signed division so that negative products truncate toward zero.
            m_rate_step = 32'(p / longint'(NINT));
        end else if (m_rate_err != 16'hffff) begin
            m_rate_err = m_rate_err + 16'd1;
        end
        if (m_early_fix != m_early_seen) begin
            m_early_seen = m_early_fix;
            m_early_st = '0;
            m_ready[0] = 1'b0;
        end else if (m_early_st >= STABLE_DONE) begin
            m_ready[0] = 1'b1;
        end else begin
            m_early_st = m_early_st + 2'd1;
        end
        if (m_late_fix != m_late_seen) begin
            m_late_seen = m_late_fix;
            m_late_st = '0;
            m_ready[1] = 1'b0;
        end else if (m_late_st >= STABLE_DONE) begin
            m_ready[1] = 1'b1;
        end else begin
            m_late_st = m_late_st + 2'd1;
        end
        if (m_rate_step > RATE_LIMIT || m_rate_step < -RATE_LIMIT) begin
            m_early_st = '0;
            m_late_st = '0;
            m_ready = '0;
        end
    endtask

    // Runs one accepted event through the model and queues its result.
    task automatic timebase_step(input ev_t e);
        logic [31:0] t;
        tb_res_t r;
        m_jam = 1'b0;
        m_tick = 1'b0;
        if (e.load) begin
            m_load_pend = 1'b1;
            m_load_val = e.ntime;
        end
        if (e.cap) begin
            t = {m_timer_high, e.cval};
            if (e.ovf && e.cval < HALF_RANGE) t = t + 32'h10000;
            m_latest = t;
        end
        if (e.ovf) m_timer_high = m_timer_high + 16'd1;
        if (e.cap && e.cmp) begin
            // A capture just before the compare is phased before the advance.
            if (16'(e.cval - m_cmp) > 16'd32767) begin
                timebase_phase(e.cval);
                timebase_advance();
            end else begin
                timebase_advance();
                timebase_phase(e.cval);
            end
        end else if (e.cap) begin
            timebase_phase(e.cval);
        end else if (e.cmp) begin
            timebase_advance();
        end
        if (e.cap) timebase_measure();
        r.compare_value = m_cmp;
        r.sync_tick     = m_tick;
        r.time_now      = m_time;
        r.capture_time  = m_latest;
        r.ready_flags   = m_ready;
        r.rate_errors   = m_rate_err;
        r.resynced      = m_jam;
        timebase_q.push_back(r);
    endtask

    // Driver: offers queued events, holds each until accepted.
    int drv_gap;
    bit in_taken;   // The offered beat was accepted at the last rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap <= 0;
        end else if (i_in_valid && !in_taken) begin
            // Beat still waiting: keep it.
        end else if (drv_gap > 0) begin
            i_in_valid <= 1'b0;
            drv_gap <= drv_gap - 1;
        end else if (event_q.size() > 0 && !quiet_mode && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            drv_gap <= $urandom_range(0, 6);
        end else if (event_q.size() > 0) begin
            ev_t e;
            e = event_q.pop_front();
            i_in_valid       <= 1'b1;
            i_overflow_event <= e.ovf;
            i_capture_event  <= e.cap;
            i_compare_event  <= e.cmp;
            i_capture_value  <= e.cval;
            i_load_time      <= e.load;
            i_new_time       <= e.ntime;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Predict at the accepting edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            timebase_step('{i_overflow_event, i_capture_event, i_compare_event,
                            i_capture_value, i_load_time, i_new_time});
        end
    end

    // Receiver ready: random stall bursts and one long hold-off.
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_request && !hold_done) begin
            i_out_ready <= 1'b0;
            stall_left <= 60;
            hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (timebase_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                tb_res_t x;
                x = timebase_q.pop_front();
                if (o_compare_value !== x.compare_value) begin
                    $error("compare_value exp %0d got %0d", x.compare_value, o_compare_value);
                    errors++;
                end
                if (o_sync_tick !== x.sync_tick) begin
                    $error("sync_tick exp %0d got %0d", x.sync_tick, o_sync_tick);
                    errors++;
                end
                if (o_time_now !== x.time_now) begin
                    $error("time_now exp %0h got %0h", x.time_now, o_time_now);
                    errors++;
                end
                if (o_capture_time !== x.capture_time) begin
                    $error("capture_time exp %0h got %0h", x.capture_time, o_capture_time);
                    errors++;
                end
                if (o_ready_flags !== x.ready_flags) begin
                    $error("ready_flags exp %0d got %0d", x.ready_flags, o_ready_flags);
                    errors++;
                end
                if (o_rate_errors !== x.rate_errors) begin
                    $error("rate_errors exp %0d got %0d", x.rate_errors, o_rate_errors);
                    errors++;
                end
                if (o_resynced !== x.resynced) begin
                    $error("resynced exp %0d got %0d", x.resynced, o_resynced);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Writes one register while the block is idle and mirrors it in the model.
    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_NOMINAL:  m_nominal  = val[15:0];
            CFG_EXPECTED: m_expected = val;
            CFG_LOW:      m_low      = val;
            CFG_HIGH:     m_high     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued event has gone in and every result has come out.
    task automatic drain();
        while (event_q.size() > 0 || i_in_valid || timebase_q.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic ev_t rand_event();
        ev_t e;
        e.ovf   = ($urandom_range(0, 3) == 0);
        e.cap   = ($urandom_range(0, 4) == 0);
        e.cmp   = ($urandom_range(0, 1) == 0);
        e.cval  = 16'($urandom);
        e.load  = ($urandom_range(0, 15) == 0);
        e.ntime = {$urandom, $urandom};
        return e;
    endfunction

    // A plausible stream: 19 to 21 compares a period, a PPS capture near
    // interval 0 or 19, overflows at random. Each period adds one second.
    task automatic queue_second(input int compares, input logic [15:0] jitter);
        ev_t e;
        for (int k = 0; k < compares; k++) begin
            e = rand_event();
            e.cap = 1'b0;
            e.cmp = 1'b1;
            event_q.push_back(e);
        end
        e = rand_event();
        e.cap = 1'b1;
        e.cmp = $urandom_range(0, 1);
        e.cval = m_cmp + jitter;
        event_q.push_back(e);
    endtask

    initial begin
        ev_t e;
        errors = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_overflow_event = 1'b0;
        i_capture_event = 1'b0;
        i_compare_event = 1'b0;
        i_capture_value = '0;
        i_load_time = 1'b0;
        i_new_time = '0;
        i_out_ready = 1'b0;

        m_nominal = NOMINAL_RST;
        m_expected = EXPECTED_RST;
        m_low = LOW_RST;
        m_high = HIGH_RST;
        {m_timer_high, m_cmp, m_prev_cmp, m_latest, m_prev_cap, m_idx} = '0;
        {m_rate_step, m_phase_step, m_rate_acc, m_phase_acc, m_time} = '0;
        {m_early_fix, m_late_fix, m_early_seen, m_late_seen} = '0;
        {m_early_st, m_late_st, m_ready, m_rate_err} = '0;
        {m_load_pend, m_load_val, m_jam, m_tick} = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every flag combination, field extremes, load, jams.
        for (int f = 0; f < 8; f++) begin
            e = '0;
            {e.ovf, e.cap, e.cmp} = f[2:0];
            e.cval = f[0] ? 16'hffff : 16'h0000;
            e.load = f[1];
            e.ntime = f[0] ? 64'hffff_ffff_ffff_ffc0 : 64'h0;
            event_q.push_back(e);
        end
        e = '0; e.ovf = 1; e.cap = 1; e.cval = 16'd32767; event_q.push_back(e);
        e = '0; e.ovf = 1; e.cap = 1; e.cval = 16'd32768; event_q.push_back(e);
        e = '0; e.load = 1; e.ntime = 64'hffff_ffff_ffff_ffff; event_q.push_back(e);
        for (int k = 0; k < 21; k++) begin
            e = '0; e.cmp = 1; e.ovf = k[0]; event_q.push_back(e);
        end
        drain();

        // Extreme configuration: tiny interval, open limits, zero expectation.
        cfg_write(CFG_NOMINAL, 32'd1);
        cfg_write(CFG_EXPECTED, 32'd0);
        cfg_write(CFG_LOW, 32'd0);
        cfg_write(CFG_HIGH, 32'hffff_ffff);
        cfg_write(8'd7, 32'hdead_beef);
        for (int k = 0; k < 100; k++) event_q.push_back(rand_event());
        drain();

        cfg_write(CFG_NOMINAL, 32'd65535);
        cfg_write(CFG_EXPECTED, 32'hffff_ffff);
        for (int k = 0; k < 100; k++) event_q.push_back(rand_event());
        // Long receiver hold-off while the sender keeps offering.
        hold_request = 1'b1;
        drain();

        // Realistic settings with well-formed seconds.
        cfg_write(CFG_NOMINAL, 32'd3200);
        cfg_write(CFG_EXPECTED, 32'd64000);
        cfg_write(CFG_LOW, 32'd60000);
        cfg_write(CFG_HIGH, 32'd68000);
        for (int s = 0; s < 12; s++) begin
            queue_second(19 + $urandom_range(0, 2), 16'($urandom_range(0, 400)) - 16'd200);
            drain();
        end
        cfg_write(CFG_NOMINAL, NOMINAL_RST);
        cfg_write(CFG_EXPECTED, EXPECTED_RST);
        cfg_write(CFG_LOW, LOW_RST);
        cfg_write(CFG_HIGH, HIGH_RST);
        quiet_mode = 1'b1;
        for (int k = 0; k < 100; k++) event_q.push_back(rand_event());
        drain();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
sv/pdtg_pkg.sv
sv/pdtg_front.sv
sv/pdtg_queue.sv
sv/pdtg_back.sv
sv/pps_disciplined_tick_generator.sv
sim/tb_pps_disciplined_tick_generator.sv
